// ===== rtl/sorted_threshold_table_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted threshold table assertion macros
// Shared wrappers for the concurrent checks of the table.
// ----------------------------------------------------------------------------
`ifndef SORTED_THRESHOLD_TABLE_MACROS_SVH
`define SORTED_THRESHOLD_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted threshold table package
// Sizes, command codes and shared types of the table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 16;

  localparam int CMD_W   = 1;
  localparam int KEY_IN_W = 16;
  localparam int TAG_W   = 16;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;

  localparam int KEY_W   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = KEY_W + TAG_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

  // Outcome of one key compare: query below entry, query at or below entry.
  typedef struct packed {
    logic lt;
    logic le;
  } stt_cmp_t;

endpackage

// ===== rtl/stt_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sorted threshold table channels
// Valid/ready channels for commands into and results out of the table.
// ----------------------------------------------------------------------------
interface stt_cmd_if import stt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_IN_W-1:0] key;
  logic [TAG_W-1:0]    tag;

  modport source (output valid, command, key, tag, input ready);
  modport sink   (input valid, command, key, tag, output ready);
endinterface

interface stt_res_if import stt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic               found;
  logic [TAG_W-1:0]   entry_tag;
  logic [COUNT_W-1:0] entry_count;
  logic               dropped;

  modport source (output valid, index, found, entry_tag, entry_count, dropped,
                  input ready);
  modport sink   (input valid, index, found, entry_tag, entry_count, dropped,
                  output ready);
endinterface

// ===== rtl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stt_cmp.sv =====
// ----------------------------------------------------------------------------
// Sorted threshold table key comparator
// Shared compare of the working key against one stored key.
// ----------------------------------------------------------------------------
module stt_cmp import stt_pkg::*; (
  input  logic [KEY_W-1:0] query_i,
  input  logic [KEY_W-1:0] entry_i,
  output stt_cmp_t         cmp_o
);

  // One subtract serves both outcomes: borrow means query below entry.
  logic [KEY_W:0] diff;

  assign diff      = {1'b0, query_i} - {1'b0, entry_i};
  assign cmp_o.lt  = diff[KEY_W];
  assign cmp_o.le  = diff[KEY_W] | (diff[KEY_W-1:0] == '0);

endmodule

// ===== rtl/sorted_threshold_table.sv =====
// ----------------------------------------------------------------------------
// Sorted threshold table
// Table of key/tag entries kept in ascending key order, with insert and
// lower-bound lookup, walked one entry per cycle through a single RAM.
// ----------------------------------------------------------------------------
// The table holds up to DEPTH entries in one RAM, sorted by key, equal keys
// in arrival order. Each command is one transfer in and one result transfer
// out. The block takes one command at a time and walks the RAM one entry per
// cycle through its read port and a single key comparator: an insert walks
// down from the last entry past each stored entry with a larger key (it
// moves each of them up by one slot), a lookup walks up from the first
// entry to the position it selects. A lookup of an empty table, or an
// insert into a full one, goes to its result without reading the RAM.
// The result sits in an output register; the next command is taken
// once the previous result has been loaded into it, so a result that is not
// taken stalls the command side for as long as it waits.
`include "sorted_threshold_table_macros.svh"

module sorted_threshold_table import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_cmd_if.sink   in_i,
  stt_res_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PLACE,
    S_LK_CMP,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   fill_q;
  logic [IDX_W-1:0]   pos_q;
  logic [KEY_W-1:0]   key_q;
  logic [TAG_W-1:0]   tag_q;

  // Pending result, then the output register.
  logic [INDEX_W-1:0] res_index_q;
  logic               res_found_q;
  logic [TAG_W-1:0]   res_tag_q;
  logic [COUNT_W-1:0] res_count_q;
  logic               res_dropped_q;

  logic               out_valid_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               out_found_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_dropped_q;

  // RAM port controls.
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  logic [KEY_W-1:0]   rd_key;
  logic [TAG_W-1:0]   rd_tag;
  stt_cmp_t           cmp;

  logic               in_xfer;
  logic               table_full;
  logic               table_empty;
  logic               lk_last;
  logic               out_free;
  logic [KEY_W-1:0]   in_key;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid & in_i.ready;
  assign in_key      = in_i.key[KEY_W-1:0];
  assign table_full  = (fill_q == CNT_W'(DEPTH));
  assign table_empty = (fill_q == '0);
  assign lk_last     = (CNT_W'(pos_q) == fill_q - 1'b1);
  assign out_free    = ~out_valid_q | out_o.ready;

  assign rd_key = rd_data[ENTRY_W-1:TAG_W];
  assign rd_tag = rd_data[TAG_W-1:0];

  stt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  stt_cmp u_cmp (
    .query_i (key_q),
    .entry_i (rd_key),
    .cmp_o   (cmp)
  );

  // RAM access for the current step of the walk.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = {key_q, tag_q};
    case (state_q)
      S_IDLE: begin
        // Fetch the last entry for an insert, the first one for a lookup.
        if (in_xfer && !table_empty) begin
          if (in_i.command == CMD_INSERT) begin
            rd_en   = !table_full;
            rd_addr = IDX_W'(fill_q - 1'b1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_INS_CMP: begin
        if (cmp.lt) begin
          // Move the larger entry up one slot, fetch the next one down.
          wr_en   = 1'b1;
          wr_data = rd_data;
          rd_en   = (pos_q != IDX_W'(1));
          rd_addr = pos_q - IDX_W'(2);
        end else begin
          wr_en = 1'b1;
        end
      end
      S_INS_PLACE: begin
        wr_en = 1'b1;
      end
      S_LK_CMP: begin
        if (!cmp.le && !lk_last) begin
          rd_en   = 1'b1;
          rd_addr = pos_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fill_q        <= '0;
      pos_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // Drop the taken result, unless a new one loads in this cycle.
      if (out_valid_q && out_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            key_q <= in_key;
            tag_q <= in_i.tag;
            if (in_i.command == CMD_INSERT) begin
              if (table_full) begin
                // Drop the insert and flag it.
                res_index_q   <= '0;
                res_found_q   <= 1'b0;
                res_tag_q     <= '0;
                res_count_q   <= COUNT_W'(fill_q);
                res_dropped_q <= 1'b1;
                state_q       <= S_DONE;
              end else if (table_empty) begin
                pos_q   <= '0;
                state_q <= S_INS_PLACE;
              end else begin
                pos_q   <= IDX_W'(fill_q);
                state_q <= S_INS_CMP;
              end
            end else begin
              if (table_empty) begin
                res_index_q   <= '0;
                res_found_q   <= 1'b0;
                res_tag_q     <= '0;
                res_count_q   <= '0;
                res_dropped_q <= 1'b0;
                state_q       <= S_DONE;
              end else begin
                pos_q   <= '0;
                state_q <= S_LK_CMP;
              end
            end
          end
        end
        S_INS_CMP: begin
          if (cmp.lt) begin
            pos_q <= pos_q - 1'b1;
            if (pos_q == IDX_W'(1)) begin
              state_q <= S_INS_PLACE;
            end
          end else begin
            fill_q        <= fill_q + 1'b1;
            res_index_q   <= INDEX_W'(pos_q);
            res_found_q   <= 1'b1;
            res_tag_q     <= tag_q;
            res_count_q   <= COUNT_W'(fill_q + 1'b1);
            res_dropped_q <= 1'b0;
            state_q       <= S_DONE;
          end
        end
        S_INS_PLACE: begin
          fill_q        <= fill_q + 1'b1;
          res_index_q   <= INDEX_W'(pos_q);
          res_found_q   <= 1'b1;
          res_tag_q     <= tag_q;
          res_count_q   <= COUNT_W'(fill_q + 1'b1);
          res_dropped_q <= 1'b0;
          state_q       <= S_DONE;
        end
        S_LK_CMP: begin
          // Stop at the first key at least the query, or at the last entry.
          if (cmp.le || lk_last) begin
            res_index_q   <= INDEX_W'(pos_q);
            res_found_q   <= 1'b1;
            res_tag_q     <= rd_tag;
            res_count_q   <= COUNT_W'(fill_q);
            res_dropped_q <= 1'b0;
            state_q       <= S_DONE;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then load it.
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_index_q   <= res_index_q;
            out_found_q   <= res_found_q;
            out_tag_q     <= res_tag_q;
            out_count_q   <= res_count_q;
            out_dropped_q <= res_dropped_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.index       = out_index_q;
  assign out_o.found       = out_found_q;
  assign out_o.entry_tag   = out_tag_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.dropped     = out_dropped_q;

  `STT_ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(DEPTH), "fill count beyond table depth")
  `STT_ASSERT(a_found_in_range, out_o.valid && out_o.found |-> INDEX_W'(out_o.index) < INDEX_W'(out_o.entry_count) || out_o.entry_count > COUNT_W'(out_o.index), "result index outside the table")
  `STT_ASSERT(a_drop_only_full, out_o.valid && out_o.dropped |-> !out_o.found && out_o.entry_count == COUNT_W'(DEPTH), "drop flagged on a table that is not full")
  `STT_ASSERT(a_place_grows, state_q == S_INS_PLACE |=> fill_q == $past(fill_q) + 1'b1, "insert did not grow the table")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted threshold table testbench
// Drives insert and lookup commands with random idle gaps and result stalls,
// tracks the expected table contents and checks every result transfer.
// ----------------------------------------------------------------------------
// The table has no delete and reset is applied once, so it fills exactly
// once per run. The random part therefore inserts rarely at first, to keep
// many table sizes in play for lookups, then inserts often near the end so
// the full-table case and dropped inserts are exercised at length.
module testbench;
  import stt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TOTAL_ITEMS  = 1300;
  localparam int FILL_PHASE   = 1000;  // items before inserts become frequent
  localparam int DRAIN_CYCLES = DEPTH + 16;

  // One result transfer, field by field.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               found;
    logic [TAG_W-1:0]   entry_tag;
    logic [COUNT_W-1:0] entry_count;
    logic               dropped;
  } table_result_t;

  // Mirror of the table contents plus the queue of results still owed.
  class table_tracker;
    logic [KEY_W-1:0] keys[DEPTH];
    logic [TAG_W-1:0] tags[DEPTH];
    int unsigned      fill;
    table_result_t    owed_results[$];
    int unsigned      failures;
    int unsigned      mismatches;
    int unsigned      stored_cnt;
    int unsigned      dropped_cnt;
    int unsigned      hit_cnt;
    int unsigned      past_end_cnt;
    int unsigned      empty_cnt;

    function new();
      fill         = 0;
      failures     = 0;
      mismatches   = 0;
      stored_cnt   = 0;
      dropped_cnt  = 0;
      hit_cnt      = 0;
      past_end_cnt = 0;
      empty_cnt    = 0;
    endfunction

    // Update the mirror for one accepted command and queue its result.
    function void take_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key,
                               logic [TAG_W-1:0] tag);
      logic [KEY_W-1:0] k;
      table_result_t    r;
      int unsigned      pos;
      bit               hit;
      k   = key[KEY_W-1:0];
      r   = '0;
      hit = 1'b0;
      if (cmd == CMD_INSERT) begin
        if (fill >= DEPTH) begin
          r.entry_count = COUNT_W'(fill);
          r.dropped     = 1'b1;
          dropped_cnt++;
        end else begin
          // Shift larger keys up; equal keys stay ahead of the new entry.
          pos = fill;
          while (pos > 0 && k < keys[pos-1]) begin
            keys[pos] = keys[pos-1];
            tags[pos] = tags[pos-1];
            pos--;
          end
          keys[pos]     = k;
          tags[pos]     = tag;
          fill++;
          r.index       = INDEX_W'(pos);
          r.found       = 1'b1;
          r.entry_tag   = tag;
          r.entry_count = COUNT_W'(fill);
          stored_cnt++;
        end
      end else if (fill == 0) begin
        empty_cnt++;
      end else begin
        pos = fill - 1;
        for (int i = 0; i < fill; i++) begin
          if (!hit && k <= keys[i]) begin
            pos = i;
            hit = 1'b1;
          end
        end
        if (hit) hit_cnt++;
        else past_end_cnt++;
        r.index       = INDEX_W'(pos);
        r.found       = 1'b1;
        r.entry_tag   = tags[pos];
        r.entry_count = COUNT_W'(fill);
      end
      owed_results.push_back(r);
    endfunction

    // Compare one result transfer against the oldest owed result.
    function void check_result(table_result_t got);
      table_result_t want;
      if (owed_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: index=%0d found=%0d tag=%h count=%0d drop=%0d",
                   $realtime, got.index, got.found, got.entry_tag, got.entry_count,
                   got.dropped);
        return;
      end
      want = owed_results.pop_front();
      if (got.index !== want.index || got.found !== want.found ||
          got.entry_tag !== want.entry_tag || got.entry_count !== want.entry_count ||
          got.dropped !== want.dropped) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result mismatch", $realtime);
          $display("  expected: index=%0d found=%0d tag=%h count=%0d drop=%0d",
                   want.index, want.found, want.entry_tag, want.entry_count, want.dropped);
          $display("  actual:   index=%0d found=%0d tag=%h count=%0d drop=%0d",
                   got.index, got.found, got.entry_tag, got.entry_count, got.dropped);
        end
      end
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction

    // Pick a key already in the table, or a random one while it is empty.
    function logic [KEY_IN_W-1:0] stored_key();
      if (fill == 0) return KEY_IN_W'($urandom);
      return KEY_IN_W'(keys[$urandom_range(0, fill - 1)]);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;        // set for stretches with back-to-back traffic
  int   stall_left;

  stt_cmd_if cmd_if ();
  stt_res_if res_if ();

  table_tracker tracker = new();

  sorted_threshold_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // 12 ns clock.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Drive every block input to a known value from time zero.
  initial begin
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_INSERT;
    cmd_if.key     = '0;
    cmd_if.tag     = '0;
    res_if.ready   = 1'b0;
    no_idle        = 1'b0;
    stall_left     = 0;
  end

  // Idle length: mostly none or short, a few long.
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: hold ready low for random stall stretches.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
        stall_left   = pick_idle();
      end
    end
  end

  // Check each result transfer at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      tracker.check_result('{index:       res_if.index,
                             found:       res_if.found,
                             entry_tag:   res_if.entry_tag,
                             entry_count: res_if.entry_count,
                             dropped:     res_if.dropped});
    end
  end

  // Give up on a hang.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench: done, errors");
    $finish;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) cycle_count++;

  // Present one command after a random idle gap and hold it until the
  // transfer; record it in the tracker at the accepting edge.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key,
                              logic [TAG_W-1:0] tag);
    int gap;
    gap = pick_idle();
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.command = cmd;
    cmd_if.key     = key;
    cmd_if.tag     = tag;
    cmd_if.valid   = 1'b1;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    tracker.take_command(cmd, key, tag);
  endtask

  // Hold the command side until every owed result has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
  endtask

  // Random key for an insert: duplicates and extremes mixed with noise.
  function automatic logic [KEY_IN_W-1:0] insert_key();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return tracker.stored_key();
    if (r == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_IN_W'($urandom);
  endfunction

  // Random query key: stored keys, their neighbors, extremes and noise.
  function automatic logic [KEY_IN_W-1:0] query_key();
    int r;
    r = $urandom_range(0, 11);
    if (r < 4) return tracker.stored_key();
    if (r == 4) return tracker.stored_key() + 1'b1;
    if (r == 5) return tracker.stored_key() - 1'b1;
    if (r == 6) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_IN_W'($urandom);
  endfunction

  initial begin
    int directed_cnt;
    bit do_insert;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty lookups, extreme keys and tags, equal keys,
    // a query above every key, and an insert that walks past most entries.
    no_idle = 1'b1;
    send_command(CMD_LOOKUP, 16'h0000, 16'h0000);
    send_command(CMD_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_command(CMD_INSERT, 16'h8000, 16'h0001);
    send_command(CMD_LOOKUP, 16'h0000, 16'hFFFF);
    send_command(CMD_LOOKUP, 16'hFFFF, 16'h0000);
    no_idle = 1'b0;
    send_command(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send_command(CMD_INSERT, 16'h0000, 16'h0000);
    send_command(CMD_INSERT, 16'h8000, 16'hAAAA);
    send_command(CMD_INSERT, 16'h8000, 16'h5555);
    send_command(CMD_LOOKUP, 16'h8000, 16'h1234);
    send_command(CMD_LOOKUP, 16'h7FFF, 16'h0000);
    send_command(CMD_LOOKUP, 16'h8001, 16'h0000);
    send_command(CMD_LOOKUP, 16'hFFFF, 16'h0000);
    send_command(CMD_LOOKUP, 16'hFFFE, 16'h0000);
    send_command(CMD_INSERT, 16'h0001, 16'h1234);
    send_command(CMD_LOOKUP, 16'h0001, 16'h0000);
    send_command(CMD_LOOKUP, 16'h0000, 16'h0000);
    directed_cnt = 17;
    drain_results();

    // Random part.
    for (int n = directed_cnt; n < TOTAL_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 250 == 0) drain_results();
      if (n < FILL_PHASE) do_insert = ($urandom_range(0, 63) == 0);
      else do_insert = ($urandom_range(0, 2) == 0);
      if (do_insert) send_command(CMD_INSERT, insert_key(), TAG_W'($urandom));
      else send_command(CMD_LOOKUP, query_key(), TAG_W'($urandom));
    end

    // Drop valid, wait out the owed results and a little more.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.owed() != 0) tracker.failures++;
    $display("covered: %0d inserts stored, %0d dropped on a full table, %0d entries held",
             tracker.stored_cnt, tracker.dropped_cnt, tracker.fill);
    $display("covered: lookups %0d hit, %0d past the last key, %0d on empty; %0d cycles",
             tracker.hit_cnt, tracker.past_end_cnt, tracker.empty_cnt, cycle_count);
    if (tracker.failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
